[design/sha_pkg.sv]
// Shared types and constants for the SHA-256 stream hasher.
// Holds the round constants, initial hash values, sequencer states and sigma helpers.
// No dependencies.
package sha_pkg;

    localparam int unsigned BLOCK_BITS = 512;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_START  = 6'd56;
    localparam logic [5:0]  FILL_LAST  = 6'd63;
    localparam logic [5:0]  ROUND_LAST = 6'd63;
    localparam logic [2:0]  WORD_LAST  = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

[design/sha256_stream_hasher_top.sv]
// SHA-256 stream hasher: byte stream in, eight-word digest stream out.
// Depends on sha_pkg (constants, states, sigma functions).
//
//  Channel  | Direction | tdata            | tuser           | tlast
//  ---------+-----------+------------------+-----------------+----------------
//  s_axis   | in        | data_byte [7:0]  | byte_present[0] | end_of_message
//  m_axis   | out       | digest_word[31:0]| word_index [2:0]| last_word
//
// Each byte word is taken when tvalid and tready are both high. The 64th byte of
// a block starts the compression, which runs one round per cycle on a single round
// unit, followed by a state that folds the working variables into the chaining
// words. At the end of a message the padding bytes go through the same byte path
// at one per cycle, pausing while a block compresses (9 to 72 bytes, with one or
// two extra compressions), then the eight digest words are offered one per cycle
// while m_axis is ready. Reset is synchronous and active low; it restores the
// initial hash values and clears the counters. While a block compresses, padding
// runs or the digest waits, s_axis tready stays low; a stalled m_axis holds the
// current digest word.
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] byte_present
    input  logic        i_s_axis_tlast,   // end_of_message
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast    // last_word
);
    import sha_pkg::*;

    // Control state.
    t_state       r_state,       n_state;
    logic [5:0]   r_fill,        n_fill;
    logic [60:0]  r_total,       n_total;
    logic [5:0]   r_round,       n_round;
    logic [2:0]   r_out_idx,     n_out_idx;
    logic         r_finishing,   n_finishing;
    logic         r_pad_first,   n_pad_first;
    logic         r_len_phase,   n_len_phase;
    logic [31:0]  r_chain [8];
    logic [31:0]  n_chain [8];

    // Datapath: the block buffer doubles as the rolling 16-word schedule window.
    logic [BLOCK_BITS-1:0] r_buf, n_buf;
    logic [31:0]  r_wv [8];
    logic [31:0]  n_wv [8];

    logic         in_fire;
    logic         wr_byte;
    logic [7:0]   wr_data;
    logic         len_byte;
    logic [63:0]  len_bits;
    logic [7:0]   pad_data;
    logic [31:0]  w_cur, w_new, t1, t2;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign len_bits = {r_total, 3'b000};

    // After the 0x80 marker, zeros run until the fill reaches byte 56; from
    // there the eight length bytes follow, most significant first.
    assign len_byte = !r_pad_first && (r_len_phase || (r_fill == LEN_START));
    always_comb begin
        priority if (r_pad_first) begin
            pad_data = PAD_MARK;
        end else if (len_byte) begin
            pad_data = 8'(len_bits >> {~r_fill[2:0], 3'b000});
        end else begin
            pad_data = 8'h00;
        end
    end

    // Round unit: window word 0 is W[t]; the next schedule word enters at the bottom.
    assign w_cur = r_buf[BLOCK_BITS-1 -: 32];
    assign w_new = w_cur + small_sigma0(r_buf[BLOCK_BITS-33 -: 32])
                 + r_buf[BLOCK_BITS-289 -: 32] + small_sigma1(r_buf[BLOCK_BITS-449 -: 32]);
    assign t1 = r_wv[7] + big_sigma1(r_wv[4])
              + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
              + K_TABLE[r_round] + w_cur;
    assign t2 = big_sigma0(r_wv[0])
              + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_total     = r_total;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_finishing = r_finishing;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_chain     = r_chain;
        n_buf       = r_buf;
        n_wv        = r_wv;
        wr_byte     = 1'b0;
        wr_data     = i_s_axis_tdata;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_finishing = i_s_axis_tlast;
                    n_pad_first = 1'b1;
                    if (i_s_axis_tuser[0]) begin
                        wr_byte = 1'b1;
                        n_total = r_total + 61'd1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                wr_byte     = 1'b1;
                wr_data     = pad_data;
                n_pad_first = 1'b0;
                if (len_byte) begin
                    n_len_phase = 1'b1;
                end
            end
            ST_ROUND: begin
                n_wv[7] = r_wv[6];
                n_wv[6] = r_wv[5];
                n_wv[5] = r_wv[4];
                n_wv[4] = r_wv[3] + t1;
                n_wv[3] = r_wv[2];
                n_wv[2] = r_wv[1];
                n_wv[1] = r_wv[0];
                n_wv[0] = t1 + t2;
                n_buf   = {r_buf[BLOCK_BITS-33:0], w_new};
                n_round = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_wv[i];
                end
                priority if (r_len_phase) begin
                    n_state   = ST_OUT;
                    n_out_idx = 3'd0;
                end else if (r_finishing) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_m_axis_tready) begin
                    // Rotate so the next digest word sits in the output slot.
                    for (int i = 0; i < 7; i++) begin
                        n_chain[i] = r_chain[i+1];
                    end
                    n_chain[7] = r_chain[0];
                    n_out_idx  = r_out_idx + 3'd1;
                    if (r_out_idx == WORD_LAST) begin
                        n_chain     = H_INIT;
                        n_fill      = 6'd0;
                        n_total     = 61'd0;
                        n_finishing = 1'b0;
                        n_len_phase = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Byte path shared by message and padding bytes; a full block starts rounds.
        if (wr_byte) begin
            n_buf  = {r_buf[BLOCK_BITS-9:0], wr_data};
            n_fill = r_fill + 6'd1;
            if (r_fill == FILL_LAST) begin
                n_state = ST_ROUND;
                n_round = 6'd0;
                n_wv    = r_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= 6'd0;
            r_total     <= 61'd0;
            r_round     <= 6'd0;
            r_out_idx   <= 3'd0;
            r_finishing <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_chain     <= H_INIT;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_finishing <= n_finishing;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_wv  <= n_wv;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_chain[0];
    assign o_m_axis_tuser  = r_out_idx;
    assign o_m_axis_tlast  = (r_out_idx == WORD_LAST);

    // The input side never opens while a digest is being offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while digest pending");

    // The last round always hands over to the chaining update.
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == ROUND_LAST) |=> (r_state == ST_FINAL))
        else $error("compression did not finish after round 63");

    // Padding always ends on a block boundary before the digest goes out.
    a_digest_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL && r_len_phase) |-> (r_fill == 6'd0))
        else $error("digest with partial block");

    // The final digest word restores the counters for the next message.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast)
        |=> (r_total == 61'd0 && r_fill == 6'd0 && o_s_axis_tready))
        else $error("hasher not reinitialized after digest");

endmodule
